/* rtl/core/pbd_pkg.sv */
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared widths, register indexes, phase states and level types for the
// pulse beat detector.
// ----------------------------------------------------------------------------
package pbd_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int ACC_WIDTH       = 32;
  localparam int DC_SHIFT        = 15;
  localparam int LEAK_SHIFT      = 4;
  localparam int SWING_WIDTH     = 16;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [SWING_WIDTH-1:0] MIN_SWING_RESET = SWING_WIDTH'(20);
  localparam logic [SWING_WIDTH-1:0] MAX_SWING_RESET = SWING_WIDTH'(1000);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_MIN_SWING = 2'd0,
    REG_MAX_SWING = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RISING,
    PH_FALLING
  } phase_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] ac;
    logic signed [SAMPLE_WIDTH-1:0] dc;
  } level_t;

endpackage

/* rtl/core/pbd_dc_tracker.sv */
// ----------------------------------------------------------------------------
// pbd_dc_tracker
// Leaky DC baseline tracker; gives the DC estimate and the saturated AC level
// of the current sample, and advances the accumulator on each item.
// ----------------------------------------------------------------------------
module pbd_dc_tracker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic signed [pbd_pkg::SAMPLE_WIDTH-1:0] sample,
  output pbd_pkg::level_t                      level
);

  localparam int SW  = pbd_pkg::SAMPLE_WIDTH;
  localparam int AW  = pbd_pkg::ACC_WIDTH;
  localparam int EW  = AW + 1;
  localparam int DW  = AW - pbd_pkg::DC_SHIFT;
  localparam int FW  = DW + 1;

  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] acc_next;
  logic signed [EW-1:0] x_scaled;
  logic signed [EW-1:0] acc_ext;
  logic signed [EW-1:0] diff;
  logic signed [EW-1:0] sum;
  logic signed [DW-1:0] avg;
  logic signed [FW-1:0] ac_full;
  logic signed [SW-1:0] ac_sat;

  localparam logic signed [SW-1:0] AC_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] AC_MIN = {1'b1, {(SW-1){1'b0}}};

  always_comb begin
    x_scaled = EW'(sample) <<< pbd_pkg::DC_SHIFT;
    acc_ext  = EW'(acc);
    diff     = x_scaled - acc_ext;
    sum      = acc_ext + (diff >>> pbd_pkg::LEAK_SHIFT);
    acc_next = sum[AW-1:0];
    avg      = acc_next[AW-1:pbd_pkg::DC_SHIFT];
    ac_full  = FW'(sample) - FW'(avg);
    if (ac_full > FW'(AC_MAX)) begin
      ac_sat = AC_MAX;
    end else if (ac_full < FW'(AC_MIN)) begin
      ac_sat = AC_MIN;
    end else begin
      ac_sat = ac_full[SW-1:0];
    end
    level.ac = ac_sat;
    level.dc = avg[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (en) begin
      acc <= acc_next;
    end
  end

endmodule

/* rtl/core/pbd_beat_fsm.sv */
// ----------------------------------------------------------------------------
// pbd_beat_fsm
// Zero-crossing phase tracker; follows peak and trough of the AC level and
// flags a beat on a rising crossing whose swing lies inside the window.
// ----------------------------------------------------------------------------
module pbd_beat_fsm (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     en,
  input  logic signed [pbd_pkg::SAMPLE_WIDTH-1:0]  ac,
  input  logic        [pbd_pkg::SWING_WIDTH-1:0]   min_swing,
  input  logic        [pbd_pkg::SWING_WIDTH-1:0]   max_swing,
  output logic                                     beat
);

  localparam int SW = pbd_pkg::SAMPLE_WIDTH;
  localparam int DW = SW + 1;
  localparam int CW = (SW > pbd_pkg::SWING_WIDTH ? SW : pbd_pkg::SWING_WIDTH) + 2;

  pbd_pkg::phase_t      phase;
  pbd_pkg::phase_t      phase_next;
  logic signed [SW-1:0] last_ac;
  logic signed [SW-1:0] peak;
  logic signed [SW-1:0] peak_next;
  logic signed [SW-1:0] trough;
  logic signed [SW-1:0] trough_next;
  logic signed [DW-1:0] swing;
  logic signed [CW-1:0] swing_ext;
  logic                 rise;
  logic                 fall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= pbd_pkg::PH_IDLE;
      last_ac <= '0;
      peak    <= '0;
      trough  <= '0;
    end else if (en) begin
      phase   <= phase_next;
      last_ac <= ac;
      peak    <= peak_next;
      trough  <= trough_next;
    end
  end

  always_comb begin
    rise      = last_ac[SW-1] && !ac[SW-1];
    fall      = !last_ac[SW-1] && (last_ac != '0) && (ac[SW-1] || (ac == '0));
    swing     = DW'(peak) - DW'(trough);
    swing_ext = CW'(swing);
    beat      = rise && (swing_ext > $signed(CW'(min_swing)))
                     && (swing_ext < $signed(CW'(max_swing)));

    unique case (phase)
      pbd_pkg::PH_IDLE,
      pbd_pkg::PH_RISING,
      pbd_pkg::PH_FALLING: begin
        if (rise) begin
          phase_next = pbd_pkg::PH_RISING;
        end else if (fall) begin
          phase_next = pbd_pkg::PH_FALLING;
        end else begin
          phase_next = phase;
        end
      end
      default: phase_next = pbd_pkg::PH_IDLE;
    endcase

    peak_next = rise ? '0 : peak;
    if (phase_next == pbd_pkg::PH_RISING && ac > last_ac) begin
      peak_next = ac;
    end
    trough_next = fall ? '0 : trough;
    if (phase_next == pbd_pkg::PH_FALLING && ac < last_ac) begin
      trough_next = ac;
    end
  end

endmodule

/* rtl/core/pulse_beat_detector_top.sv */
// ----------------------------------------------------------------------------
// pulse_beat_detector_top
// Optical pulse beat detector: DC removal and zero-crossing beat detection.
// ----------------------------------------------------------------------------
// One sample item is accepted per clock cycle, sustained while out_stall is
// low. An accepted item waits in the input register and passes through the
// DC tracker and crossing logic into the result register, where its result
// item appears.
// That rate is set by the feedback through the DC accumulator and
// the previous AC level, both updated in the same cycle an item leaves the
// input register. Input stall rises only while the input register is full and
// the result register holds an item that is stalled. min_swing and max_swing
// are written through cfg_write/cfg_index/cfg_data; unknown indexes are
// ignored.
module pulse_beat_detector_top (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  logic signed [pbd_pkg::SAMPLE_WIDTH-1:0]    sample_value,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output logic                                       beat_found,
  output logic signed [pbd_pkg::SAMPLE_WIDTH-1:0]    ac_level,
  output logic signed [pbd_pkg::SAMPLE_WIDTH-1:0]    dc_level,
  input  logic                                       cfg_write,
  input  logic        [pbd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic        [pbd_pkg::SWING_WIDTH-1:0]     cfg_data
);

  logic                                    s1_valid;
  logic signed [pbd_pkg::SAMPLE_WIDTH-1:0] s1_sample;
  logic                                    advance;
  logic [pbd_pkg::SWING_WIDTH-1:0]         min_swing;
  logic [pbd_pkg::SWING_WIDTH-1:0]         max_swing;
  pbd_pkg::level_t                         level;
  logic                                    beat;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_swing <= pbd_pkg::MIN_SWING_RESET;
      max_swing <= pbd_pkg::MAX_SWING_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pbd_pkg::REG_MIN_SWING: min_swing <= cfg_data;
        pbd_pkg::REG_MAX_SWING: max_swing <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_sample <= sample_value;
    end
  end

  pbd_dc_tracker u_dc (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .sample (s1_sample),
    .level  (level)
  );

  pbd_beat_fsm u_beat (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .ac        (level.ac),
    .min_swing (min_swing),
    .max_swing (max_swing),
    .beat      (beat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      beat_found <= beat;
      ac_level   <= level.ac;
      dc_level   <= level.dc;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a held item");

  a_item_reaches_output: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_stall |=> out_valid)
    else $error("held item did not reach the result register");

  a_reset_empties: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");

endmodule
